[rtl/core/psma_pkg.sv]
// ----------------------------------------------------------------------------
// psma_pkg
// Shared types and constants for the positive-sample moving average unit.
// ----------------------------------------------------------------------------
package psma_pkg;

  localparam int SAMPLE_W = 23;           // magnitude bits of an accepted sample
  localparam int IN_W     = 24;           // raw input width, two's complement
  localparam int FRAC_W   = 8;            // fraction bits
  localparam int LIMIT_W  = 8;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 8'd30;
  localparam logic [LIMIT_W-1:0] IDLE_RUN_MAX     = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUB,
    ST_UPDATE,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } psma_state_t;

  typedef struct packed {
    logic accept;
    logic rd_oldest;
    logic sub_oldest;
    logic update;
    logic div_start;
    logic div_step;
    logic load_out;
  } psma_cmd_t;

  typedef struct packed {
    logic in_idle;
    logic ring_full;
    logic div_last;
  } psma_stat_t;

endpackage

[rtl/core/psma_dp.sv]
// ----------------------------------------------------------------------------
// psma_dp
// Datapath: idle counter, sample ring, running sum, serial divider and the
// output register.
// ----------------------------------------------------------------------------
module psma_dp #(
  parameter int WINDOW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [23:0]          sample,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  psma_pkg::psma_cmd_t  cmd,
  output psma_pkg::psma_stat_t stat,
  output logic [22:0]          average,
  output logic                 idle_zeroed
);
  import psma_pkg::*;

  localparam int SLW = $clog2(WINDOW);
  localparam int FW  = $clog2(WINDOW + 1);
  localparam int SW  = SAMPLE_W + SLW;
  localparam int CW  = $clog2(SW);

  logic [SAMPLE_W-1:0] ring [WINDOW];

  logic [LIMIT_W-1:0]  idle_limit;
  logic [LIMIT_W-1:0]  idle_run;
  logic [LIMIT_W-1:0]  idle_run_inc;
  logic                zero_flag;
  logic [SAMPLE_W-1:0] sample_reg;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SW-1:0]       running_sum;
  logic [FW-1:0]       fill_count;
  logic [SLW-1:0]      oldest_slot;
  logic [SAMPLE_W-1:0] last_average;
  logic                ring_full;
  logic [SLW-1:0]      wr_addr;

  logic [SW-1:0]       work;
  logic [SW-1:0]       work_next;
  logic [FW-1:0]       rem;
  logic [FW-1:0]       rem_next;
  logic [FW-1:0]       divisor;
  logic [FW:0]         trial;
  logic [FW:0]         diff;
  logic [CW-1:0]       div_cnt;

  // below 1.0 or negative counts as idle
  assign stat.in_idle   = sample[IN_W-1] || (sample[SAMPLE_W-1:FRAC_W] == '0);
  assign ring_full      = (fill_count == FW'(WINDOW));
  assign stat.ring_full = ring_full;
  assign stat.div_last  = (div_cnt == '0);

  assign idle_run_inc = (idle_run == IDLE_RUN_MAX) ? idle_run : idle_run + 1'b1;
  assign wr_addr      = ring_full ? oldest_slot : fill_count[SLW-1:0];

  // restoring divide, one quotient bit a cycle
  assign trial     = {rem, work[SW-1]};
  assign diff      = trial - {1'b0, divisor};
  assign rem_next  = diff[FW] ? trial[FW-1:0] : diff[FW-1:0];
  assign work_next = {work[SW-2:0], ~diff[FW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      idle_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_run     <= '0;
      running_sum  <= '0;
      fill_count   <= '0;
      oldest_slot  <= '0;
      last_average <= '0;
    end else begin
      if (cmd.accept) begin
        idle_run <= stat.in_idle ? idle_run_inc : '0;
      end
      if (cmd.sub_oldest) begin
        running_sum <= running_sum - SW'(rd_data);
      end
      if (cmd.update) begin
        running_sum <= running_sum + SW'(sample_reg);
        if (ring_full) begin
          oldest_slot <= (oldest_slot == SLW'(WINDOW - 1)) ? '0 : oldest_slot + 1'b1;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (cmd.div_step && stat.div_last) begin
        last_average <= work_next[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_reg <= sample[SAMPLE_W-1:0];
      zero_flag  <= stat.in_idle && (idle_run_inc >= idle_limit);
    end
    if (cmd.rd_oldest) begin
      rd_data <= ring[oldest_slot];
    end
    if (cmd.update) begin
      ring[wr_addr] <= sample_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      work    <= running_sum;
      rem     <= '0;
      divisor <= fill_count;
      div_cnt <= CW'(SW - 1);
    end else if (cmd.div_step) begin
      work    <= work_next;
      rem     <= rem_next;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average     <= zero_flag ? '0 : last_average;
      idle_zeroed <= zero_flag;
    end
  end

endmodule

[rtl/core/psma_ctrl.sv]
// ----------------------------------------------------------------------------
// psma_ctrl
// Controller: sequences ring update and division, owns the handshakes.
// ----------------------------------------------------------------------------
module psma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  psma_pkg::psma_stat_t stat,
  output psma_pkg::psma_cmd_t  cmd
);
  import psma_pkg::*;

  psma_state_t state;
  psma_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_idle) begin
            state_next = ST_EMIT;
          end else if (stat.ring_full) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_READ: begin
        cmd.rd_oldest = 1'b1;
        state_next    = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub_oldest = 1'b1;
        state_next     = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DSTART;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/positive_sample_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// positive_sample_moving_average_unit
// Windowed mean of positive angular-velocity samples with idle zeroing.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one 24-bit signed sample (8 fraction
// bits) per request. Output channel: out_valid/out_ready carry one result,
// average (23 bits) and idle_zeroed, for every sample taken.
// cfg_wr_en/cfg_wr_data write idle_limit (reset 30); write only when idle.
// Sequence: an idle sample (below 1.0) goes from accept straight to EMIT; an
// active sample passes UPDATE, DSTART and DIV first (ring not yet full), or
// READ, SUB, UPDATE, DSTART and DIV (full). SW = 23 + clog2(WINDOW) is the
// number of steps of the bit-serial divider by the fill count.
// Results pass from the last divide step through EMIT into the output register.
// The output register decouples the sides: a new sample is taken while a
// result waits; if the receiver stalls, the following result waits in the
// controller until the register frees up, and no further sample is taken.
// Reset clears the sum, fill count, idle counter and last average; the ring
// needs no clearing since an entry is only read once the ring is full.
// ----------------------------------------------------------------------------
module positive_sample_moving_average_unit #(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] average,
  output logic        idle_zeroed,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import psma_pkg::*;

  psma_cmd_t  cmd;
  psma_stat_t stat;

  psma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psma_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .average     (average),
    .idle_zeroed (idle_zeroed)
  );

endmodule
